// File: design/ssmva_pkg.sv
`timescale 1ns / 1ps

package ssmva_pkg;

  localparam int IDX_W    = 12;
  localparam int NARROW_W = 24;
  localparam int WIDE_W   = 48;
  localparam int IDX_SPAN = 1 << IDX_W;

  typedef logic [1:0]                 action_t;
  typedef logic [IDX_W-1:0]           idx_t;
  typedef logic signed [NARROW_W-1:0] narrow_t;
  typedef logic signed [WIDE_W-1:0]   wide_t;

  localparam action_t ACT_LOAD_X  = 2'd0;
  localparam action_t ACT_LOAD_B  = 2'd1;
  localparam action_t ACT_NONZERO = 2'd2;
  localparam action_t ACT_READ_B  = 2'd3;

  typedef struct packed {
    logic ld_xr;
    logic ld_xc;
    logic mul_row;
    logic mul_col;
    logic sum_acc;
    logic b_upd;
    logic b_fold;
    logic b_ok;
  } mac_ctrl_t;

endpackage

// File: design/ssmva_in_if.sv
`timescale 1ns / 1ps

interface ssmva_in_if;
  logic                 valid;
  logic                 ready;
  ssmva_pkg::action_t   action;
  ssmva_pkg::idx_t      row_index;
  ssmva_pkg::idx_t      col_index;
  ssmva_pkg::narrow_t   narrow_value;
  ssmva_pkg::wide_t     wide_value;
  logic                 last_in_row;

  modport source (
    output valid, action, row_index, col_index, narrow_value, wide_value, last_in_row,
    input  ready
  );

  modport sink (
    input  valid, action, row_index, col_index, narrow_value, wide_value, last_in_row,
    output ready
  );
endinterface

// File: design/ssmva_out_if.sv
`timescale 1ns / 1ps

interface ssmva_out_if;
  logic              valid;
  logic              ready;
  ssmva_pkg::idx_t   out_index;
  ssmva_pkg::wide_t  out_value;
  logic              saturated;

  modport source (
    output valid, out_index, out_value, saturated,
    input  ready
  );

  modport sink (
    input  valid, out_index, out_value, saturated,
    output ready
  );
endinterface

// File: design/ssmva_ram.sv
`timescale 1ns / 1ps

module ssmva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/ssmva_mac.sv
`timescale 1ns / 1ps

module ssmva_mac (
  input  logic                 clk,
  input  logic                 rst,
  input  ssmva_pkg::mac_ctrl_t ctrl,
  input  ssmva_pkg::narrow_t   coef,
  input  ssmva_pkg::narrow_t   x_operand,
  input  ssmva_pkg::wide_t     b_data,
  output ssmva_pkg::wide_t     b_wdata,
  output logic                 saturated
);

  localparam int W = ssmva_pkg::WIDE_W;
  localparam ssmva_pkg::wide_t WIDE_MAX = {1'b0, {(W-1){1'b1}}};
  localparam ssmva_pkg::wide_t WIDE_MIN = {1'b1, {(W-1){1'b0}}};

  ssmva_pkg::narrow_t xr;
  ssmva_pkg::narrow_t xc;
  ssmva_pkg::narrow_t mul_b;
  ssmva_pkg::wide_t   product;
  ssmva_pkg::wide_t   p_row;
  ssmva_pkg::wide_t   p_col;
  ssmva_pkg::wide_t   row_sum;
  ssmva_pkg::wide_t   addend;
  ssmva_pkg::wide_t   row_sum_next;
  logic [W:0]         sum_b;
  logic [W:0]         sum_r;
  logic               b_ovf;
  logic               r_ovf;
  logic               sat;

  assign mul_b   = ctrl.mul_col ? xc : xr;
  assign product = coef * mul_b;

  // saturating add into the b entry, or fold of the row sum
  assign addend = ctrl.b_fold ? row_sum : p_row;
  assign sum_b  = {b_data[W-1], b_data} + {addend[W-1], addend};
  assign b_ovf  = sum_b[W] ^ sum_b[W-1];
  assign b_wdata = b_ovf ? (sum_b[W] ? WIDE_MIN : WIDE_MAX) : sum_b[W-1:0];

  // saturating add into the row sum
  assign sum_r = {row_sum[W-1], row_sum} + {p_col[W-1], p_col};
  assign r_ovf = sum_r[W] ^ sum_r[W-1];
  assign row_sum_next = r_ovf ? (sum_r[W] ? WIDE_MIN : WIDE_MAX) : sum_r[W-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.ld_xr) begin
      xr <= x_operand;
    end
    if (ctrl.ld_xc) begin
      xc <= x_operand;
    end
    if (ctrl.mul_row) begin
      p_row <= product;
    end
    if (ctrl.mul_col) begin
      p_col <= product;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_sum <= '0;
      sat     <= 1'b0;
    end else begin
      if (ctrl.sum_acc) begin
        row_sum <= row_sum_next;
      end else if (ctrl.b_fold) begin
        row_sum <= '0;
      end
      if (((ctrl.b_upd || ctrl.b_fold) && ctrl.b_ok && b_ovf) || (ctrl.sum_acc && r_ovf)) begin
        sat <= 1'b1;
      end
    end
  end

  assign saturated = sat;

endmodule

// File: design/symmetric_sparse_matvec_accumulate_core.sv
`timescale 1ns / 1ps
// loads of x or b write at the transfer; a read returns via the b read register and the result register
// a matrix nonzero steps through XROW, XCOL, MUL and UPD, then FOLDRD and FOLD when it carries the last-in-row mark
// the sequence is set by the single read port of the x and b memories and the shared multiplier
// reset: synchronous; afterwards a sweep zeroes all min(VECTOR_LENGTH, 4096) entries of the b memory
// and no item is taken until it is done; x memory is not cleared

module symmetric_sparse_matvec_accumulate_core #(
  parameter int VECTOR_LENGTH = 4096
) (
  input logic        clk,
  input logic        rst,
  ssmva_in_if.sink   item,
  ssmva_out_if.source result
);

  localparam int IDX_W = ssmva_pkg::IDX_W;
  localparam int DEPTH = (VECTOR_LENGTH < ssmva_pkg::IDX_SPAN) ? VECTOR_LENGTH
                                                               : ssmva_pkg::IDX_SPAN;
  localparam int AW = $clog2(DEPTH);
  localparam logic [IDX_W:0] DEPTH_CMP = (IDX_W+1)'(DEPTH);
  localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_XROW   = 4'd2;
  localparam logic [3:0] S_XCOL   = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_UPD    = 4'd5;
  localparam logic [3:0] S_FOLDRD = 4'd6;
  localparam logic [3:0] S_FOLD   = 4'd7;
  localparam logic [3:0] S_READ   = 4'd8;

  logic [3:0]    state;
  logic [3:0]    state_next;
  logic [AW-1:0] clr_cnt;

  ssmva_pkg::idx_t    row;
  ssmva_pkg::idx_t    col;
  ssmva_pkg::narrow_t coef;
  logic               last;
  logic               diag;
  logic               row_ok;
  logic               col_ok;
  logic               tgt_ok;
  ssmva_pkg::idx_t    tgt;

  logic accept;
  logic in_row_ok;
  logic in_col_ok;
  logic out_free;

  logic               x_we;
  logic               x_re;
  logic [AW-1:0]      x_raddr;
  ssmva_pkg::narrow_t x_rdata;
  ssmva_pkg::narrow_t x_operand;

  logic             b_we;
  logic [AW-1:0]    b_waddr;
  ssmva_pkg::wide_t b_wdata;
  logic             b_re;
  logic [AW-1:0]    b_raddr;
  ssmva_pkg::wide_t b_rdata;
  ssmva_pkg::wide_t mac_wdata;

  ssmva_pkg::mac_ctrl_t mac_ctrl;
  logic                 sat_flag;

  logic             out_valid;
  ssmva_pkg::idx_t  out_index;
  ssmva_pkg::wide_t out_value;
  logic             out_sat;

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign in_row_ok  = ({1'b0, item.row_index} < DEPTH_CMP);
  assign in_col_ok  = ({1'b0, item.col_index} < DEPTH_CMP);
  assign out_free   = !out_valid || result.ready;
  assign tgt        = diag ? row : col;
  assign tgt_ok     = diag ? row_ok : col_ok;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (item.action)
            ssmva_pkg::ACT_NONZERO: state_next = S_XROW;
            ssmva_pkg::ACT_READ_B:  state_next = S_READ;
            default:                state_next = S_IDLE;
          endcase
        end
      end
      S_XROW:   state_next = S_XCOL;
      S_XCOL:   state_next = S_MUL;
      S_MUL:    state_next = S_UPD;
      S_UPD:    state_next = last ? S_FOLDRD : S_IDLE;
      S_FOLDRD: state_next = S_FOLD;
      S_FOLD:   state_next = S_IDLE;
      S_READ: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      row    <= item.row_index;
      col    <= item.col_index;
      coef   <= item.narrow_value;
      last   <= item.last_in_row;
      diag   <= (item.row_index == item.col_index);
      row_ok <= in_row_ok;
      col_ok <= in_col_ok;
    end
  end

  // x memory
  assign x_we    = accept && (item.action == ssmva_pkg::ACT_LOAD_X) && in_row_ok;
  assign x_re    = (accept && (item.action == ssmva_pkg::ACT_NONZERO)) || (state == S_XROW);
  assign x_raddr = (state == S_XROW) ? col[AW-1:0] : item.row_index[AW-1:0];

  always_comb begin
    if (state == S_XROW) begin
      x_operand = row_ok ? x_rdata : '0;
    end else begin
      x_operand = col_ok ? x_rdata : '0;
    end
  end

  ssmva_ram #(
    .WIDTH (ssmva_pkg::NARROW_W),
    .DEPTH (DEPTH)
  ) u_x_ram (
    .clk   (clk),
    .we    (x_we),
    .waddr (item.row_index[AW-1:0]),
    .wdata (item.narrow_value),
    .re    (x_re),
    .raddr (x_raddr),
    .rdata (x_rdata)
  );

  // b memory
  always_comb begin
    b_we    = 1'b0;
    b_waddr = row[AW-1:0];
    b_wdata = mac_wdata;
    b_re    = 1'b0;
    b_raddr = row[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        b_we    = 1'b1;
        b_waddr = clr_cnt;
        b_wdata = '0;
      end
      S_IDLE: begin
        b_we    = accept && (item.action == ssmva_pkg::ACT_LOAD_B) && in_row_ok;
        b_waddr = item.row_index[AW-1:0];
        b_wdata = item.wide_value;
        b_re    = accept && (item.action == ssmva_pkg::ACT_READ_B);
        b_raddr = item.row_index[AW-1:0];
      end
      S_XCOL: begin
        b_re    = 1'b1;
        b_raddr = tgt[AW-1:0];
      end
      S_UPD: begin
        b_we    = tgt_ok;
        b_waddr = tgt[AW-1:0];
      end
      S_FOLDRD: begin
        b_re = 1'b1;
      end
      S_FOLD: begin
        b_we = row_ok;
      end
      default: begin
        b_we = 1'b0;
      end
    endcase
  end

  ssmva_ram #(
    .WIDTH (ssmva_pkg::WIDE_W),
    .DEPTH (DEPTH)
  ) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .re    (b_re),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  always_comb begin
    mac_ctrl         = '0;
    mac_ctrl.ld_xr   = (state == S_XROW);
    mac_ctrl.ld_xc   = (state == S_XCOL);
    mac_ctrl.mul_row = (state == S_XCOL);
    mac_ctrl.mul_col = (state == S_MUL);
    mac_ctrl.sum_acc = (state == S_UPD) && !diag;
    mac_ctrl.b_upd   = (state == S_UPD);
    mac_ctrl.b_fold  = (state == S_FOLD);
    mac_ctrl.b_ok    = (state == S_FOLD) ? row_ok : tgt_ok;
  end

  ssmva_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (mac_ctrl),
    .coef      (coef),
    .x_operand (x_operand),
    .b_data    (b_rdata),
    .b_wdata   (mac_wdata),
    .saturated (sat_flag)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_READ) && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_READ) && out_free) begin
      out_index <= row;
      out_value <= row_ok ? b_rdata : '0;
      out_sat   <= sat_flag;
    end
  end

  assign result.valid     = out_valid;
  assign result.out_index = out_index;
  assign result.out_value = out_value;
  assign result.saturated = out_sat;

endmodule
